// ----- rtl/sorted_priority_queue_core_defines.svh -----
// assertion helpers shared by the checker
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    // default sizing
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_VALUE_BITS = 16;

    // operation codes carried by the input item
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- rtl/spq_in_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [VALUE_BITS-1:0] prio_in;

    modport source (output valid, output op, output prio_in, input ready);
    modport sink   (input valid, input op, input prio_in, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
`timescale 1ns / 1ps

interface spq_out_if #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 5
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] prio_out;
    logic                  was_empty;
    logic                  overflow;
    logic [COUNT_BITS-1:0] fill_count;

    modport source (output valid, output prio_out, output was_empty,
                    output overflow, output fill_count, input ready);
    modport sink   (input valid, input prio_out, input was_empty,
                    input overflow, input fill_count, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 5,
    parameter int CELL_IDX   = 0
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_ctrl    i_ctrl,
    input  logic [VALUE_BITS-1:0]  i_push_value,
    input  logic [COUNT_BITS-1:0]  i_count,
    input  logic [VALUE_BITS-1:0]  i_left_value,
    input  logic                   i_left_gt,
    input  logic [VALUE_BITS-1:0]  i_right_value,
    output logic [VALUE_BITS-1:0]  o_value,
    output logic                   o_gt
);
    import spq_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  w_occupied;

    // cell holds a live entry when its index is below the fill count
    assign w_occupied = i_count > COUNT_BITS'(CELL_IDX);

    // stored value must move behind the new one
    assign o_gt    = w_occupied && (r_value > i_push_value);
    assign o_value = r_value;

    // shift right on insert, shift left on removal
    always_comb begin
        n_value = r_value;
        if (i_ctrl.push) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt || !w_occupied) begin
                n_value = i_push_value;
            end
        end else if (i_ctrl.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// a result item is registered and shown in the cycle after its input item is accepted
// throughput: one item per cycle while each result is taken; every cell compares and shifts in the same cycle
// a result item left waiting holds off the input; one taken in the same cycle lets the next in
// reset (synchronous, active low) empties the queue and drops any pending result
// stored values are not cleared; the fill count alone marks which cells are live

module sorted_priority_queue_core #(
    parameter int DEPTH      = spq_pkg::DEFAULT_DEPTH,
    parameter int VALUE_BITS = spq_pkg::DEFAULT_VALUE_BITS,
    parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_prio_out;
    logic                  r_was_empty;
    logic                  r_overflow;
    logic [COUNT_BITS-1:0] r_fill_count;

    logic       w_accept;
    logic       w_is_pop;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic                  w_gt    [DEPTH];

    // handshake and command decode
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_pop   = t_op'(i_in.op) == OP_POP;
    assign w_full     = r_count == COUNT_BITS'(DEPTH);
    assign w_empty    = r_count == '0;
    assign w_ctrl.push = w_accept && !w_is_pop && !w_full;
    assign w_ctrl.pop  = w_accept && w_is_pop && !w_empty;

    // fill count update
    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + COUNT_BITS'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - COUNT_BITS'(1);
        end
    end

    // row of cells, front at index zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left_value;
        logic                  w_left_gt;
        logic [VALUE_BITS-1:0] w_right_value;

        if (g == 0) begin : g_first
            assign w_left_value = '0;
            assign w_left_gt    = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_value[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_in.prio_in),
            .i_count       (r_count),
            .i_left_value  (w_left_value),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .o_value       (w_value[g]),
            .o_gt          (w_gt[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prio_out   <= w_ctrl.pop ? w_value[0] : '0;
            r_was_empty  <= w_is_pop && w_empty;
            r_overflow   <= !w_is_pop && w_full;
            r_fill_count <= n_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.prio_out   = r_prio_out;
    assign o_out.was_empty  = r_was_empty;
    assign o_out.overflow   = r_overflow;
    assign o_out.fill_count = r_fill_count;

endmodule

// ----- rtl/spq_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module spq_assert_checker #(
    parameter int DEPTH      = spq_pkg::DEFAULT_DEPTH,
    parameter int VALUE_BITS = spq_pkg::DEFAULT_VALUE_BITS,
    parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [VALUE_BITS-1:0] i_prio_out,
    input logic                  i_was_empty,
    input logic                  i_overflow,
    input logic [COUNT_BITS-1:0] i_fill_count
);
    import spq_pkg::*;

    // an accepted item shows its result in the next cycle
    `SPQ_ASSERT_NEXT(a_result_next, i_in_valid && i_in_ready, i_out_valid,
        "result item missing after accept")

    // an empty pop leaves nothing stored and returns zero
    `SPQ_ASSERT_SAME(a_empty_pop, i_out_valid && i_was_empty,
        i_fill_count == '0 && i_prio_out == '0, "empty pop with live entries or value")

    // a dropped push only happens with every cell in use
    `SPQ_ASSERT_SAME(a_overflow_full, i_out_valid && i_overflow,
        i_fill_count == COUNT_BITS'(DEPTH) && !i_was_empty, "overflow while not full")

    // a stalled result item holds
    `SPQ_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_prio_out) && $stable(i_fill_count)
        && $stable(i_was_empty) && $stable(i_overflow), "stalled result item changed")

endmodule

bind sorted_priority_queue_core spq_assert_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_spq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_prio_out   (o_out.prio_out),
    .i_was_empty  (o_out.was_empty),
    .i_overflow   (o_out.overflow),
    .i_fill_count (o_out.fill_count)
);
